/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the string unescaper.
// Bodies collapse to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/jsu_pkg.sv */
// Package of the JSON string unescaper: widths, codes, phase type, decode helpers.
// No dependencies.
`timescale 1ns / 1ps
package jsu_pkg;

    localparam int COUNT_BITS = 16;
    localparam int LIM_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_U      = 8'h75;
    localparam logic [7:0]  CH_QMARK  = 8'h3F;
    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [15:0] CP_LIMIT  = 16'd128;
    localparam logic [15:0] MAX_RESET = 16'd255;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_STR,
        PH_ESC,
        PH_HEX,
        PH_DONE,
        PH_RPL,
        PH_FIN
    } t_phase;

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [7:0] ch;
        logic       consume;
    } t_act;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // {valid, character}
    function automatic logic [8:0] esc_char(input logic [7:0] b);
        case (b)
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            CH_SLASH:  return {1'b1, CH_SLASH};
            8'h62:     return {1'b1, 8'h08};
            8'h66:     return {1'b1, 8'h0C};
            8'h6E:     return {1'b1, 8'h0A};
            8'h72:     return {1'b1, 8'h0D};
            8'h74:     return {1'b1, 8'h09};
            default:   return 9'd0;
        endcase
    endfunction

endpackage

/* hdl/jsu_if.sv */
// Channel interfaces of the JSON string unescaper: input bytes, results, config writes.
// No dependencies.
`timescale 1ns / 1ps
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;
    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       last;
    modport source (output valid, output kind, output char_out, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input last, output ready);
endinterface

interface jsu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_chars;
    modport source (output valid, output max_chars, input ready);
    modport sink   (input valid, input max_chars, output ready);
endinterface

/* hdl/json_string_unescaper.sv */
// Streaming decoder for one quoted JSON string value, one raw byte per item.
// Depends on jsu_pkg, jsu_if.sv and assert_macros.svh.
//
// Usage:
//   i_in   : raw bytes of the JSON text, end_of_input marks the last byte.
//   o_out  : results; kind 0 is a decoded character, 1 success, 2 failure;
//            last marks the final result of an input byte.
//   i_cfg  : write of max_chars, always ready; write only while idle.
// An accepted item waits in the input register; its first result is
// registered in the result register when the output is not stalled.
// Throughput: one item per cycle for plain bytes and complete escapes
// while o_out.ready is high. A byte that yields several results holds the
// input register until its last result: a character on the last input
// byte yields the character, then a failure; a broken escape replays
// backslash, u and up to three held digits, then handles the byte itself.
// Reset: waiting for an opening quote, counters cleared, max_chars = 255.
// Stall: while o_out.ready is low the result register holds and one more
// item is taken into the input register, then i_in.ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module json_string_unescaper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_cfg_if.sink   i_cfg,
    jsu_out_if.source o_out
);

    logic                            r_in_v;
    logic [7:0]                      r_byte;
    logic                            r_eoi;
    jsu_pkg::t_phase                 r_phase, n_phase;
    logic [1:0]                      r_hex, n_hex;
    logic [7:0]                      r_held [3];
    logic [7:0]                      n_held [3];
    logic [11:0]                     r_code, n_code;
    logic [jsu_pkg::COUNT_BITS-1:0]  r_cnt, n_cnt;
    logic [2:0]                      r_rep, n_rep;
    logic                            r_had_u, n_had_u;
    logic [15:0]                     r_max;
    logic                            r_o_v;
    logic [1:0]                      r_kind;
    logic [7:0]                      r_char;
    logic                            r_last;

    logic                            go;
    logic                            in_take;
    logic [jsu_pkg::LIM_W-1:0]       w_max, w_cmax, w_lim;
    logic [jsu_pkg::COUNT_BITS-1:0]  cnt_inc;
    logic                            at_lim, at_lim_next;
    logic                            is_quote, is_bs, is_nul, is_u;
    logic [4:0]                      hx;
    logic [8:0]                      es;
    logic [15:0]                     cp;
    logic [7:0]                      cp_ch;
    logic [2:0]                      rep_idx, rep_last;
    logic                            had_u_eff, rep_end;
    logic [7:0]                      rep_ch;
    jsu_pkg::t_phase                 end_ph, plain_ph, rpl_ph;
    jsu_pkg::t_act                   act, plain_act, rpl_act;

    assign go      = r_in_v && (!r_o_v || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready     = !r_in_v || (go && act.consume);
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_o_v;
    assign o_out.kind     = r_kind;
    assign o_out.char_out = r_char;
    assign o_out.last     = r_last;

    assign w_max       = jsu_pkg::LIM_W'(r_max);
    assign w_cmax      = jsu_pkg::LIM_W'(jsu_pkg::CNT_MAX);
    assign w_lim       = (w_max > w_cmax) ? w_cmax : w_max;
    assign cnt_inc     = (r_cnt == jsu_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign at_lim      = jsu_pkg::LIM_W'(r_cnt) >= w_lim;
    assign at_lim_next = jsu_pkg::LIM_W'(cnt_inc) >= w_lim;

    assign is_quote = r_byte == jsu_pkg::CH_QUOTE;
    assign is_bs    = r_byte == jsu_pkg::CH_BSLASH;
    assign is_nul   = r_byte == jsu_pkg::CH_NUL;
    assign is_u     = r_byte == jsu_pkg::CH_U;
    assign hx       = jsu_pkg::hex_val(r_byte);
    assign es       = jsu_pkg::esc_char(r_byte);
    assign cp       = {r_code, hx[3:0]};
    assign cp_ch    = (cp < jsu_pkg::CP_LIMIT) ? cp[7:0] : jsu_pkg::CH_QMARK;

    assign rep_idx   = (r_phase == jsu_pkg::PH_RPL) ? r_rep : 3'd0;
    assign had_u_eff = (r_phase == jsu_pkg::PH_RPL) ? r_had_u : (r_phase == jsu_pkg::PH_HEX);
    assign rep_last  = had_u_eff ? 3'd1 + 3'(r_hex) : 3'd0;
    assign rep_end   = rep_idx == rep_last;

    always_comb begin
        case (rep_idx)
            3'd0:    rep_ch = jsu_pkg::CH_BSLASH;
            3'd1:    rep_ch = jsu_pkg::CH_U;
            3'd2:    rep_ch = r_held[0];
            3'd3:    rep_ch = r_held[1];
            default: rep_ch = r_held[2];
        endcase
    end

    // Result and consume decision for the byte in the input register.
    always_comb begin
        plain_act = '{emit: 1'b0, kind: jsu_pkg::KIND_CHAR, ch: 8'h00, consume: 1'b0};
        if (at_lim || is_quote || is_nul) begin
            plain_act.emit    = 1'b1;
            plain_act.kind    = is_quote ? jsu_pkg::KIND_OK : jsu_pkg::KIND_FAIL;
            plain_act.consume = 1'b1;
        end else if (is_bs && !r_eoi) begin
            plain_act.consume = 1'b1;
        end else begin
            plain_act.emit    = 1'b1;
            plain_act.ch      = r_byte;
            plain_act.consume = !r_eoi;
        end

        rpl_act = '{emit: 1'b1, kind: jsu_pkg::KIND_CHAR, ch: 8'h00, consume: 1'b0};
        if (at_lim) begin
            rpl_act.kind    = jsu_pkg::KIND_FAIL;
            rpl_act.consume = 1'b1;
        end else begin
            rpl_act.ch      = rep_ch;
            rpl_act.consume = rep_end && is_bs && !r_eoi && !at_lim_next;
        end

        act = '{emit: 1'b0, kind: jsu_pkg::KIND_CHAR, ch: 8'h00, consume: 1'b0};
        unique case (r_phase)
            jsu_pkg::PH_WAIT: begin
                act.consume = 1'b1;
                if (!(is_quote && !r_eoi)) begin
                    act.emit = 1'b1;
                    act.kind = jsu_pkg::KIND_FAIL;
                end
            end
            jsu_pkg::PH_STR: act = plain_act;
            jsu_pkg::PH_ESC: begin
                if (es[8]) begin
                    act.emit    = 1'b1;
                    act.ch      = es[7:0];
                    act.consume = !r_eoi;
                end else if (is_u && !r_eoi) begin
                    act.consume = 1'b1;
                end else begin
                    act = rpl_act;
                end
            end
            jsu_pkg::PH_HEX: begin
                if (hx[4] && r_hex == 2'd3) begin
                    act.emit    = 1'b1;
                    act.ch      = cp_ch;
                    act.consume = !r_eoi;
                end else if (hx[4] && !r_eoi) begin
                    act.consume = 1'b1;
                end else begin
                    act = rpl_act;
                end
            end
            jsu_pkg::PH_RPL: act = rpl_act;
            jsu_pkg::PH_FIN: begin
                act.emit    = 1'b1;
                act.kind    = jsu_pkg::KIND_FAIL;
                act.consume = 1'b1;
            end
            jsu_pkg::PH_DONE: act.consume = 1'b1;
            default:          act.consume = 1'b1;
        endcase
    end

    // Next state.
    always_comb begin
        end_ph = r_eoi ? jsu_pkg::PH_WAIT : jsu_pkg::PH_DONE;

        if (at_lim || is_quote || is_nul) begin
            plain_ph = end_ph;
        end else if (is_bs && !r_eoi) begin
            plain_ph = jsu_pkg::PH_ESC;
        end else begin
            plain_ph = r_eoi ? jsu_pkg::PH_FIN : jsu_pkg::PH_STR;
        end

        if (at_lim) begin
            rpl_ph = end_ph;
        end else if (!rep_end) begin
            rpl_ph = jsu_pkg::PH_RPL;
        end else if (is_bs && !r_eoi && !at_lim_next) begin
            rpl_ph = jsu_pkg::PH_ESC;
        end else begin
            rpl_ph = jsu_pkg::PH_STR;
        end

        n_phase = r_phase;
        n_hex   = r_hex;
        n_code  = r_code;
        n_held  = r_held;
        n_cnt   = r_cnt;
        n_rep   = r_rep;
        n_had_u = r_had_u;

        if (go) begin
            if (act.emit && act.kind == jsu_pkg::KIND_CHAR) begin
                n_cnt = cnt_inc;
            end
            if (rpl_ph == jsu_pkg::PH_RPL) begin
                n_rep   = rep_idx + 3'd1;
                n_had_u = had_u_eff;
            end else if (rep_end && !at_lim) begin
                n_rep = 3'd0;
            end
            unique case (r_phase)
                jsu_pkg::PH_WAIT: begin
                    if (is_quote && !r_eoi) begin
                        n_phase = jsu_pkg::PH_STR;
                        n_cnt   = '0;
                        n_hex   = 2'd0;
                        n_code  = 12'd0;
                    end else begin
                        n_phase = end_ph;
                    end
                end
                jsu_pkg::PH_STR: n_phase = plain_ph;
                jsu_pkg::PH_ESC: begin
                    if (es[8]) begin
                        n_phase = r_eoi ? jsu_pkg::PH_FIN : jsu_pkg::PH_STR;
                    end else if (is_u && !r_eoi) begin
                        n_phase = jsu_pkg::PH_HEX;
                        n_hex   = 2'd0;
                        n_code  = 12'd0;
                    end else begin
                        n_phase = rpl_ph;
                    end
                end
                jsu_pkg::PH_HEX: begin
                    if (hx[4] && r_hex == 2'd3) begin
                        n_hex   = 2'd0;
                        n_phase = r_eoi ? jsu_pkg::PH_FIN : jsu_pkg::PH_STR;
                    end else if (hx[4] && !r_eoi) begin
                        n_held[r_hex] = r_byte;
                        n_code        = {r_code[7:0], hx[3:0]};
                        n_hex         = r_hex + 2'd1;
                    end else begin
                        n_phase = rpl_ph;
                        if (rep_end && !at_lim) begin
                            n_hex = 2'd0;
                        end
                    end
                end
                jsu_pkg::PH_RPL: begin
                    n_phase = rpl_ph;
                    if (rep_end && !at_lim) begin
                        n_hex = 2'd0;
                    end
                end
                jsu_pkg::PH_FIN:  n_phase = jsu_pkg::PH_WAIT;
                jsu_pkg::PH_DONE: n_phase = r_eoi ? jsu_pkg::PH_WAIT : jsu_pkg::PH_DONE;
                default:          n_phase = jsu_pkg::PH_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_phase <= jsu_pkg::PH_WAIT;
            r_hex   <= 2'd0;
            r_code  <= 12'd0;
            r_cnt   <= '0;
            r_rep   <= 3'd0;
            r_had_u <= 1'b0;
            r_max   <= jsu_pkg::MAX_RESET;
            r_o_v   <= 1'b0;
            r_held  <= '{default: 8'h00};
        end else begin
            if (in_take) begin
                r_in_v <= 1'b1;
            end else if (go && act.consume) begin
                r_in_v <= 1'b0;
            end
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_code  <= n_code;
            r_cnt   <= n_cnt;
            r_rep   <= n_rep;
            r_had_u <= n_had_u;
            r_held  <= n_held;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.max_chars;
            end
            if (go && act.emit) begin
                r_o_v <= 1'b1;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_in.in_byte;
            r_eoi  <= i_in.end_of_input;
        end
        if (go && act.emit) begin
            r_kind <= act.kind;
            r_char <= act.ch;
            r_last <= act.consume;
        end
    end

    `ASSERT_ALWAYS(a_fin_has_item, i_clk, i_rst_n, (r_phase != jsu_pkg::PH_FIN) || r_in_v)
    `ASSERT_ALWAYS(a_rep_in_range, i_clk, i_rst_n, (r_phase != jsu_pkg::PH_RPL) || (r_rep <= rep_last))
    `ASSERT_NEXT(a_end_is_last, i_clk, i_rst_n, go && act.emit && act.kind != jsu_pkg::KIND_CHAR, r_o_v && r_last)

endmodule
